// File: rtl/decimating_box_downscale_assert.svh
// assertion macros shared by the checker file
`ifndef DECIMATING_BOX_DOWNSCALE_ASSERT_SVH
`define DECIMATING_BOX_DOWNSCALE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DBD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define DBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/dbd_pkg.sv
package dbd_pkg;

    localparam int MAX_OUT_WIDTH = 4096;
    localparam int NUM_CHAN      = 4;
    localparam int CHAN_W        = 8;
    localparam int PAIR_W        = 10;
    localparam int PIXEL_W       = 32;
    localparam int RATIO_W       = 5;
    localparam int PHASE_W       = 4;
    localparam int COUNT_W       = 13;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 13;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RATIO     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH = 2'd2;

    // pixel format codes
    localparam logic FMT_RGBA8888 = 1'b0;
    localparam logic FMT_RGB565   = 1'b1;

    localparam logic [RATIO_W-1:0] RATIO_MIN = 5'd2;
    localparam logic [RATIO_W-1:0] RATIO_MAX = 5'd16;

    typedef logic [CHAN_W-1:0] chan_t;

    typedef struct packed {
        logic clear;
        logic load;
    } lane_ctl_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] out_pixel;
        logic               row_last;
    } result_t;

    // pull one channel out of a pixel, zero extended to a byte
    function automatic chan_t chan_of(input logic [PIXEL_W-1:0] px,
                                      input logic [1:0] c,
                                      input logic fmt);
        chan_t v;
        v = '0;
        if (fmt == FMT_RGBA8888) begin
            unique case (c)
                2'd0: v = px[7:0];
                2'd1: v = px[15:8];
                2'd2: v = px[23:16];
                default: v = px[31:24];
            endcase
        end else begin
            unique case (c)
                2'd0: v = {3'b000, px[15:11]};
                2'd1: v = {2'b00, px[10:5]};
                2'd2: v = {3'b000, px[4:0]};
                default: v = '0;
            endcase
        end
        return v;
    endfunction

endpackage

// File: rtl/dbd_lane.sv
module dbd_lane import dbd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  lane_ctl_t ctl,
    input  chan_t     top_chan,
    input  chan_t     bottom_chan,
    output chan_t     avg_chan
);

    logic [PAIR_W-1:0] partial_reg;
    logic [PAIR_W-1:0] partial_next;
    logic [PAIR_W-1:0] pair_sum;
    logic [PAIR_W:0]   quad_sum;

    assign pair_sum = PAIR_W'(top_chan) + PAIR_W'(bottom_chan);
    assign quad_sum = {1'b0, partial_reg} + {1'b0, pair_sum};
    // divide by four, truncating
    assign avg_chan = quad_sum[CHAN_W+1:2];

    always_comb begin
        partial_next = partial_reg;
        if (ctl.load) begin
            partial_next = pair_sum;
        end else if (ctl.clear) begin
            partial_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= '0;
        end else begin
            partial_reg <= partial_next;
        end
    end

endmodule

// File: rtl/dbd_merge.sv
module dbd_merge import dbd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  logic               fmt,
    input  chan_t              avg [NUM_CHAN],
    input  logic               row_last,
    input  logic               m_ready,
    output logic               m_valid,
    output logic [PIXEL_W-1:0] m_out_pixel,
    output logic               m_row_last,
    output logic               skid_full
);

    result_t packed_res;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    pop;

    always_comb begin
        if (fmt == FMT_RGBA8888) begin
            packed_res.out_pixel = {avg[3], avg[2], avg[1], avg[0]};
        end else begin
            packed_res.out_pixel = {16'h0000, avg[0][4:0], avg[1][5:0], avg[2][4:0]};
        end
        packed_res.row_last = row_last;
    end

    assign pop = out_valid_reg && m_ready;

    // output register backed by one skid entry; push never comes while skid is full
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (push) begin
                if (!out_valid_reg || pop) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (pop) begin
                if (skid_valid_reg) begin
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            if (!out_valid_reg || pop) begin
                out_reg <= packed_res;
            end else begin
                skid_reg <= packed_res;
            end
        end else if (pop && skid_valid_reg) begin
            out_reg <= skid_reg;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_out_pixel = out_reg.out_pixel;
    assign m_row_last  = out_reg.row_last;
    assign skid_full   = skid_valid_reg;

endmodule

// File: rtl/decimating_box_downscale.sv
// 2x2 box downscaler with column decimation. Each transfer on the s_ side carries one
// column of two source rows (upper and lower pixel); of every group of ratio columns
// the two adjacent ones starting at offset (ratio-2)/2 are averaged per channel into
// one output pixel, truncating. Format is RGBA8888 (red in bits 7:0) or RGB565 in the
// low 16 bits, upper bits zero. s_row_start restarts the group phase and output count;
// after out_width outputs the rest of the row is swallowed without results. A new
// column is accepted every clock while s_ready is high: four channel lanes add the pixel
// pair and the stored first-column sum in the accept cycle, and the packed result is
// registered into the output register or the skid entry, which decouple the sides,
// so input keeps flowing while a result waits; s_ready drops only when both are held.
// Config writes (cfg_wr_en/cfg_index/cfg_wdata) take effect the next cycle and must
// be done while the block is idle; index 0 ratio, 1 pixel_format, 2 out_width.
module decimating_box_downscale import dbd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // config write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // source column transfer
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PIXEL_W-1:0]    s_top_pixel,
    input  logic [PIXEL_W-1:0]    s_bottom_pixel,
    input  logic                  s_row_start,
    // output pixel transfer
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [PIXEL_W-1:0]    m_out_pixel,
    output logic                  m_row_last
);

    // config registers
    logic [RATIO_W-1:0]   ratio_reg;
    logic                 format_reg;
    logic [COUNT_W-1:0]   out_width_reg;

    // row state
    logic [PHASE_W-1:0]   phase_reg;
    logic [PHASE_W-1:0]   phase_next;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic                 row_done_reg;
    logic                 row_done_next;

    logic                 accept;
    logic                 skid_full;
    logic [RATIO_W-1:0]   ratio_eff;
    logic [RATIO_W-1:0]   ratio_less2;
    logic [PHASE_W-1:0]   first_col;
    logic [PHASE_W:0]     second_col;
    logic [COUNT_W-1:0]   width_eff;
    logic [PHASE_W-1:0]   phase_eff;
    logic [PHASE_W:0]     phase_inc;
    logic [COUNT_W-1:0]   count_eff;
    logic [COUNT_W-1:0]   count_inc;
    logic                 active;
    logic                 is_first;
    logic                 is_second;
    logic                 emit;
    logic                 last_out;
    lane_ctl_t            lane_ctl;
    chan_t                avg [NUM_CHAN];

    assign s_ready = !skid_full;
    assign accept  = s_valid && s_ready;

    // config writes, masked to the register widths; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio_reg     <= RATIO_MIN;
            format_reg    <= FMT_RGBA8888;
            out_width_reg <= COUNT_W'(MAX_OUT_WIDTH);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_RATIO:     ratio_reg     <= cfg_wdata[RATIO_W-1:0];
                REG_FORMAT:    format_reg    <= cfg_wdata[0];
                REG_OUT_WIDTH: out_width_reg <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp config into its legal range
    always_comb begin
        if (ratio_reg < RATIO_MIN) begin
            ratio_eff = RATIO_MIN;
        end else if (ratio_reg > RATIO_MAX) begin
            ratio_eff = RATIO_MAX;
        end else begin
            ratio_eff = ratio_reg;
        end
        if (out_width_reg == '0) begin
            width_eff = COUNT_W'(1);
        end else if (out_width_reg > COUNT_W'(MAX_OUT_WIDTH)) begin
            width_eff = COUNT_W'(MAX_OUT_WIDTH);
        end else begin
            width_eff = out_width_reg;
        end
    end

    // kept columns sit at (ratio-2)/2 and the one after it
    assign ratio_less2 = ratio_eff - RATIO_MIN;
    assign first_col   = ratio_less2[RATIO_W-1:1];
    assign second_col  = {1'b0, first_col} + (PHASE_W+1)'(1);

    // row start acts as if the state was cleared just before this column
    assign phase_eff = s_row_start ? '0 : phase_reg;
    assign count_eff = s_row_start ? '0 : count_reg;
    assign active    = s_row_start || !row_done_reg;

    assign is_first  = (phase_eff == first_col);
    assign is_second = ({1'b0, phase_eff} == second_col);
    assign count_inc = count_eff + COUNT_W'(1);
    assign last_out  = (count_inc >= width_eff);
    assign emit      = accept && active && is_second;

    // phase wraps at the group end, also when a shrunk ratio left it past the end
    assign phase_inc = {1'b0, phase_eff} + (PHASE_W+1)'(1);

    always_comb begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        row_done_next = row_done_reg;
        if (accept && active) begin
            phase_next    = (phase_inc >= ratio_eff) ? '0 : phase_inc[PHASE_W-1:0];
            count_next    = is_second ? count_inc : count_eff;
            row_done_next = is_second && last_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= '0;
            count_reg    <= '0;
            row_done_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            row_done_reg <= row_done_next;
        end
    end

    // partial sums: load on the first kept column, cleared by row start
    assign lane_ctl.clear = accept && s_row_start;
    assign lane_ctl.load  = accept && active && is_first;

    // one lane per channel
    for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
        dbd_lane u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (lane_ctl),
            .top_chan    (chan_of(s_top_pixel, 2'(c), format_reg)),
            .bottom_chan (chan_of(s_bottom_pixel, 2'(c), format_reg)),
            .avg_chan    (avg[c])
        );
    end

    // pack the channel averages and hold the result for the output side
    dbd_merge u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (emit),
        .fmt         (format_reg),
        .avg         (avg),
        .row_last    (last_out),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_out_pixel (m_out_pixel),
        .m_row_last  (m_row_last),
        .skid_full   (skid_full)
    );

endmodule

// File: rtl/dbd_checker.sv
`include "decimating_box_downscale_assert.svh"

module dbd_checker import dbd_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [PIXEL_W-1:0] m_out_pixel,
    input logic               m_row_last
);

    // a stalled result holds
    `DBD_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_out_pixel) && $stable(m_row_last), "stalled result changed")

    // input backs off only when results are waiting
    `DBD_ASSERT_NOW(a_stall_needs_result, !s_ready, m_valid, "s_ready low with no result pending")

    // both entries stay held while the output is stalled
    `DBD_ASSERT_NEXT(a_full_stays, !s_ready && !m_ready, !s_ready, "skid entry lost during stall")

    // one result taken frees room for the next column
    `DBD_ASSERT_NEXT(a_full_drains, !s_ready && m_ready, s_ready, "s_ready stuck after result transfer")

endmodule

bind decimating_box_downscale dbd_checker u_dbd_checker (.*);

// File: tb/decimating_box_downscale_checker.sv
`timescale 1ns / 1ps

module decimating_box_downscale_checker import dbd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [PIXEL_W-1:0]    s_top_pixel,
    input  logic [PIXEL_W-1:0]    s_bottom_pixel,
    input  logic                  s_row_start,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [PIXEL_W-1:0]    m_out_pixel,
    input  logic                  m_row_last,
    output int unsigned           mismatches,
    output int unsigned           pending,
    output int unsigned           checked
);

    // register copies
    logic [RATIO_W-1:0]  ratio_q;
    logic                fmt_q;
    logic [COUNT_W-1:0]  width_q;

    // row state
    logic [PHASE_W-1:0]  phase_q;
    logic [COUNT_W-1:0]  count_q;
    logic [PAIR_W-1:0]   held_sum [NUM_CHAN];
    logic                done_q;

    result_t             expected_px [$];
    int unsigned         err_n;
    int unsigned         ok_n;

    function automatic logic [PAIR_W-1:0] lane_value(input logic [PIXEL_W-1:0] px,
                                                     input int c, input logic fmt);
        if (fmt == FMT_RGBA8888)
            return PAIR_W'(px[8*c +: 8]);
        case (c)
            0: return PAIR_W'(px[15:11]);
            1: return PAIR_W'(px[10:5]);
            2: return PAIR_W'(px[4:0]);
            default: return '0;
        endcase
    endfunction

    task automatic downscale_column(input logic [PIXEL_W-1:0] upper,
                                    input logic [PIXEL_W-1:0] lower,
                                    input logic restart);
        int unsigned r;
        int unsigned w;
        int unsigned first;
        int unsigned ph;
        int unsigned total;
        logic [PAIR_W-1:0] fresh [NUM_CHAN];
        logic [7:0] avg [NUM_CHAN];
        result_t res;
        r = ratio_q;
        if (r < RATIO_MIN) r = RATIO_MIN;
        else if (r > RATIO_MAX) r = RATIO_MAX;
        w = width_q;
        if (w == 0) w = 1;
        else if (w > MAX_OUT_WIDTH) w = MAX_OUT_WIDTH;
        first = (r - 2) / 2;
        if (restart) begin
            phase_q = '0;
            count_q = '0;
            foreach (held_sum[c]) held_sum[c] = '0;
            done_q = 1'b0;
        end
        if (done_q) return;
        foreach (fresh[c])
            fresh[c] = lane_value(upper, c, fmt_q) + lane_value(lower, c, fmt_q);
        if (phase_q == first) begin
            held_sum = fresh;
        end else if (phase_q == first + 1) begin
            foreach (avg[c]) begin
                total = int'(held_sum[c]) + int'(fresh[c]);
                avg[c] = 8'(total >> 2);
            end
            count_q = count_q + 1'b1;
            if (fmt_q == FMT_RGBA8888)
                res.out_pixel = {avg[3], avg[2], avg[1], avg[0]};
            else
                res.out_pixel = {16'h0000, avg[0][4:0], avg[1][5:0], avg[2][4:0]};
            res.row_last = (count_q >= w);
            if (res.row_last) done_q = 1'b1;
            expected_px.push_back(res);
        end
        ph = phase_q;
        if (ph + 1 >= r) phase_q = '0;
        else phase_q = PHASE_W'(ph + 1);
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            ratio_q = RATIO_MIN;
            fmt_q   = FMT_RGBA8888;
            width_q = COUNT_W'(MAX_OUT_WIDTH);
            phase_q = '0;
            count_q = '0;
            foreach (held_sum[c]) held_sum[c] = '0;
            done_q  = 1'b0;
            expected_px.delete();
            err_n   = 0;
            ok_n    = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_RATIO:     ratio_q = cfg_wdata[RATIO_W-1:0];
                    REG_FORMAT:    fmt_q   = cfg_wdata[0];
                    REG_OUT_WIDTH: width_q = cfg_wdata[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_px.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %08h row_last %0b",
                             $time, m_out_pixel, m_row_last);
                    err_n++;
                end else begin
                    want = expected_px.pop_front();
                    if (m_out_pixel !== want.out_pixel) begin
                        $display("%0t: out_pixel expected %08h actual %08h",
                                 $time, want.out_pixel, m_out_pixel);
                        err_n++;
                    end
                    if (m_row_last !== want.row_last) begin
                        $display("%0t: row_last expected %0b actual %0b",
                                 $time, want.row_last, m_row_last);
                        err_n++;
                    end
                    ok_n++;
                end
            end
            if (s_valid && s_ready)
                downscale_column(s_top_pixel, s_bottom_pixel, s_row_start);
        end
        mismatches <= err_n;
        pending    <= expected_px.size();
        checked    <= ok_n;
    end

endmodule

// File: tb/tb_decimating_box_downscale.sv
`timescale 1ns / 1ps

module tb_decimating_box_downscale;
    import dbd_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 10;
    // result is registered after the column, with a skid entry behind it
    localparam int DRAIN_SETTLE = 8;
    localparam int IDLE_PCT     = 58;
    localparam int BOTH_PCT     = 21;
    localparam int RANDOM_ITEMS = 1600;
    localparam int NUM_PLANS    = 12;
    localparam int RUN_LIMIT_NS = 2_000_000;

    typedef enum int {
        FLOW_FREE,
        FLOW_SRC_IDLE,
        FLOW_SINK_STALL,
        FLOW_BOTH
    } flow_mode_t;

    logic                  aclk;
    logic                  aresetn        = 1'b0;
    logic                  cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index      = REG_RATIO;
    logic [CFG_DATA_W-1:0] cfg_wdata      = '0;
    logic                  s_valid        = 1'b0;
    logic [PIXEL_W-1:0]    s_top_pixel    = '0;
    logic [PIXEL_W-1:0]    s_bottom_pixel = '0;
    logic                  s_row_start    = 1'b0;
    logic                  m_ready        = 1'b0;
    logic                  s_ready;
    logic                  m_valid;
    logic [PIXEL_W-1:0]    m_out_pixel;
    logic                  m_row_last;

    int unsigned           mismatches;
    int unsigned           pending;
    int unsigned           checked;

    // flow control knobs, percent per cycle
    int unsigned           src_idle_pct   = 0;
    int unsigned           sink_stall_pct = 0;

    // clamped copies of the current setting, used to shape rows
    int unsigned           cur_ratio      = 2;
    int unsigned           cur_width      = MAX_OUT_WIDTH;

    int unsigned           columns_sent   = 0;
    int unsigned           rows_started   = 0;
    int unsigned           settings_used  = 0;

    // random sweep plan, extremes and out of range values included
    int unsigned plan_ratio [NUM_PLANS] = '{2, 16, 5, 1, 0, 31, 7, 4, 3, 6, 9, 2};
    logic        plan_fmt   [NUM_PLANS] = '{FMT_RGBA8888, FMT_RGB565, FMT_RGBA8888,
                                            FMT_RGB565, FMT_RGBA8888, FMT_RGB565,
                                            FMT_RGBA8888, FMT_RGB565, FMT_RGBA8888,
                                            FMT_RGB565, FMT_RGBA8888, FMT_RGB565};
    int unsigned plan_width [NUM_PLANS] = '{1, 3, 7, 4, 2, 2, 0, 8191, 4096, 5, 3, 12};

    decimating_box_downscale u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_top_pixel    (s_top_pixel),
        .s_bottom_pixel (s_bottom_pixel),
        .s_row_start    (s_row_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_pixel    (m_out_pixel),
        .m_row_last     (m_row_last)
    );

    decimating_box_downscale_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_top_pixel    (s_top_pixel),
        .s_bottom_pixel (s_bottom_pixel),
        .s_row_start    (s_row_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_pixel    (m_out_pixel),
        .m_row_last     (m_row_last),
        .mismatches     (mismatches),
        .pending        (pending),
        .checked        (checked)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // hard stop in case the handshake hangs
    initial begin
        #(RUN_LIMIT_NS);
        $display("Mismatches found");
        $finish;
    end

    // output side backpressure, a fresh draw every cycle
    always @(posedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic set_flow(input flow_mode_t mode);
        case (mode)
            FLOW_FREE: begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end
            FLOW_SRC_IDLE: begin
                src_idle_pct   = IDLE_PCT;
                sink_stall_pct = 0;
            end
            FLOW_SINK_STALL: begin
                src_idle_pct   = 0;
                sink_stall_pct = IDLE_PCT;
            end
            default: begin
                src_idle_pct   = BOTH_PCT;
                sink_stall_pct = BOTH_PCT;
            end
        endcase
    endtask

    // one column transfer; valid stays high afterwards so the caller must
    // either send again or drop valid in the same step
    task automatic send_column(input logic [PIXEL_W-1:0] upper,
                               input logic [PIXEL_W-1:0] lower,
                               input logic restart);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_top_pixel    <= upper;
        s_bottom_pixel <= lower;
        s_row_start    <= restart;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        columns_sent++;
        if (restart) rows_started++;
    endtask

    // stop the source and let every pending output pixel come out
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        // a swallowed column may still sit in the pipe
        repeat (DRAIN_SETTLE) @(posedge aclk);
    endtask

    // write all three registers back to back, block must be idle
    task automatic load_settings(input int unsigned ratio_val, input logic fmt_val,
                                 input int unsigned width_val);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_RATIO;
        cfg_wdata <= CFG_DATA_W'(ratio_val);
        @(posedge aclk);
        cfg_index <= REG_FORMAT;
        cfg_wdata <= CFG_DATA_W'(fmt_val);
        @(posedge aclk);
        cfg_index <= REG_OUT_WIDTH;
        cfg_wdata <= CFG_DATA_W'(width_val);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        // the block clamps out of range values, rows follow the clamped ones
        cur_ratio = ratio_val & 5'h1f;
        if (cur_ratio < RATIO_MIN) cur_ratio = RATIO_MIN;
        else if (cur_ratio > RATIO_MAX) cur_ratio = RATIO_MAX;
        cur_width = width_val & 13'h1fff;
        if (cur_width == 0) cur_width = 1;
        else if (cur_width > MAX_OUT_WIDTH) cur_width = MAX_OUT_WIDTH;
        settings_used++;
    endtask

    // mostly random content, with all-zero and all-one pixels mixed in
    function automatic logic [PIXEL_W-1:0] rand_pixel();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // rows sized to the current setting; some are cut short, overrun,
    // missing their row start or restarted early
    task automatic run_rows(input int unsigned budget);
        int unsigned used;
        int unsigned span;
        int unsigned len;
        int unsigned i;
        logic        restart;
        used = 0;
        while (used < budget) begin
            span = cur_ratio * cur_width;
            if ($urandom_range(9) < 8)
                len = span + $urandom_range(cur_ratio - 1);
            else
                len = 1 + $urandom_range(span + 2 * cur_ratio);
            for (i = 0; i < len && used < budget; i++) begin
                if (i == 0)
                    restart = ($urandom_range(19) != 0);
                else
                    restart = ($urandom_range(99) == 0);
                send_column(rand_pixel(), rand_pixel(), restart);
                // tail columns after the row is full are swallowed, not counted
                if (i < span) used++;
            end
        end
    endtask

    initial begin
        int unsigned p;
        set_flow(FLOW_FREE);
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings, row begun at reset without any row start
        send_column('0, '0, 1'b0);
        send_column('1, '1, 1'b0);
        send_column('1, '0, 1'b0);
        send_column(32'h0103_0507, 32'h0204_0608, 1'b0);
        hold_until_drained();

        // rgb565, group of three, row of two outputs then swallowed tail
        load_settings(3, FMT_RGB565, 2);
        send_column(32'hffff_ffff, 32'hffff_ffff, 1'b1);
        send_column(32'h1234_f800, 32'h0000_07e0, 1'b0);
        send_column(32'hdead_001f, 32'hbeef_ffff, 1'b0);
        send_column('0, '0, 1'b0);
        send_column(32'h0000_ffff, '0, 1'b0);
        send_column('1, '1, 1'b0);
        send_column(32'h5555_aaaa, 32'haaaa_5555, 1'b0);
        hold_until_drained();

        // widest group, then the ratio shrinks under a phase past the group
        load_settings(16, FMT_RGBA8888, 4096);
        send_column(32'h8080_8080, 32'h7f7f_7f7f, 1'b1);
        repeat (8) send_column(rand_pixel(), rand_pixel(), 1'b0);
        hold_until_drained();
        load_settings(4, FMT_RGBA8888, 4096);
        repeat (4) send_column(rand_pixel(), rand_pixel(), 1'b0);
        hold_until_drained();

        // second kept column arrives without its first one
        send_column('1, '1, 1'b1);
        hold_until_drained();
        load_settings(2, FMT_RGBA8888, 4096);
        send_column('1, '1, 1'b0);

        // format flips between the two kept columns
        send_column('1, '1, 1'b0);
        hold_until_drained();
        load_settings(2, FMT_RGB565, 4096);
        send_column(32'h0000_ffff, 32'hffff_ffff, 1'b0);
        hold_until_drained();

        // random sweep over the settings plan, flow mode rotating
        for (p = 0; p < NUM_PLANS; p++) begin
            load_settings(plan_ratio[p], plan_fmt[p], plan_width[p]);
            set_flow(flow_mode_t'(p % 4));
            run_rows(RANDOM_ITEMS / NUM_PLANS);
            hold_until_drained();
        end

        $display("covered %0d column transfers in %0d started rows over %0d register settings",
                 columns_sent, rows_started, settings_used);
        $display("compared %0d output pixels, all flow modes and out of range settings",
                 checked);
        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
